FILE: rtl/rgb_to_hls_converter_macros.svh
// assertion macros for the rgb to hls converter
// used by rgb_to_hls_converter.sv, no other dependencies
`ifndef RGB_TO_HLS_CONVERTER_MACROS_SVH
`define RGB_TO_HLS_CONVERTER_MACROS_SVH

// same-cycle implication
`define HLS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hls check failed");

// next-cycle implication
`define HLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hls check failed");

`endif

FILE: rtl/hls_pkg.sv
// shared types and constants for the rgb to hls converter
// no dependencies
package hls_pkg;

  localparam int HLS_SCALE   = 240;
  localparam int RGB_FULL    = 255;
  localparam int GREY_HUE    = (HLS_SCALE * 2) / 3;
  localparam int HUE_SIXTH   = HLS_SCALE / 6;
  localparam int HUE_THIRD   = HLS_SCALE / 3;
  localparam int LIGHT_DEN   = 2 * RGB_FULL;
  // lightness <= scale/2 exactly when max+min is at most this
  localparam int SAT_SPLIT   = 256;

  // divider geometry
  localparam int DIV_NUM_W   = 17;
  localparam int DIV_DEN_W   = 9;
  localparam int DIV_QUO_W   = 8;
  localparam int DIV_STAGES  = 4;
  localparam int DIV_BITS    = DIV_QUO_W / DIV_STAGES;

  // lightness divides by the constant 2*255: ceil(2^26 / 510) is exact
  // for every numerator below 2^17
  localparam int LIGHT_RECIP  = 131587;
  localparam int LIGHT_SHIFT  = 26;
  localparam int LIGHT_PROD_W = DIV_NUM_W + 18;

  // stages ahead of the dividers plus the output stage
  localparam int PIPE_DEPTH  = 3 + DIV_STAGES + 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] lightness;
    logic [7:0] saturation;
  } hls_out_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic    grey;
    sector_t sector;
  } side_t;

endpackage

FILE: rtl/hls_div.sv
// pipelined restoring divider, DIV_BITS quotient bits per stage
// depends on hls_pkg
module hls_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hls_pkg::DIV_NUM_W-1:0] num,
  input  logic [hls_pkg::DIV_DEN_W-1:0] den,
  output logic [hls_pkg::DIV_QUO_W-1:0] quo
);
  import hls_pkg::*;

  logic [DIV_NUM_W-1:0] rem_r [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_r [DIV_STAGES];
  logic [DIV_QUO_W-1:0] quo_r [DIV_STAGES];
  logic [DIV_NUM_W-1:0] rem_nxt [DIV_STAGES];
  logic [DIV_QUO_W-1:0] quo_nxt [DIV_STAGES];
  logic [DIV_NUM_W-1:0] rem_in [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_in [DIV_STAGES];
  logic [DIV_QUO_W-1:0] quo_in [DIV_STAGES];

  // stage inputs: first from ports, rest from previous stage
  assign rem_in[0] = num;
  assign den_in[0] = den;
  assign quo_in[0] = '0;
  for (genvar g = 1; g < DIV_STAGES; g++) begin : g_link
    assign rem_in[g] = rem_r[g-1];
    assign den_in[g] = den_r[g-1];
    assign quo_in[g] = quo_r[g-1];
  end

  // compare and subtract, high quotient bits first
  always_comb begin
    logic [DIV_NUM_W-1:0] rem;
    logic [DIV_NUM_W-1:0] trial;
    logic [DIV_QUO_W-1:0] q;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem = rem_in[s];
      q   = quo_in[s];
      for (int b = 0; b < DIV_BITS; b++) begin
        trial = DIV_NUM_W'(den_in[s]) << (DIV_QUO_W - 1 - DIV_BITS * s - b);
        if (rem >= trial) begin
          rem = rem - trial;
          q[$clog2(DIV_QUO_W)'(DIV_QUO_W - 1 - DIV_BITS * s - b)] = 1'b1;
        end
      end
      rem_nxt[s] = rem;
      quo_nxt[s] = q;
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= den_in[s];
        quo_r[s] <= quo_nxt[s];
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

FILE: rtl/rgb_to_hls_converter.sv
// RGB pixel to hue, lightness, saturation (0..240 scale)
// input beat: in_valid/in_ready with in_data {red, green, blue}, 8 bits each
// result beat: out_valid/out_ready with out_data {hue, lightness, saturation}
// every accepted pixel gives exactly one result, in order
// pipeline: three front stages, a four-stage divider (two quotient bits per stage)
//   and the output register lie between accept and out_valid
// throughput: one pixel per cycle while out_ready stays high
// saturation and the three channel deltas run in parallel divider
//   pipelines; lightness divides by a constant through a reciprocal
//   multiply and is delayed to line up with them
// stall: when the output register holds a beat and out_ready is low, the
//   whole pipeline freezes and in_ready drops; nothing is lost or repeated
// reset: synchronous, active low rst_n, clears all valid bits; the block
//   takes a pixel in the first cycle after reset
// grey pixels give saturation 0 and hue 160
// depends on hls_pkg, hls_div and rgb_to_hls_converter_macros.svh
`include "rgb_to_hls_converter_macros.svh"

module rgb_to_hls_converter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hls_pkg::pix_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hls_pkg::hls_out_t out_data
);
  import hls_pkg::*;

  logic                 en;
  logic [PIPE_DEPTH-1:0] vld_r;

  // stage 1 input pixel
  pix_in_t              pix_r;
  // stage 2 sum and spread of max and min, channel deltas and sector
  logic [8:0]           sum_r;
  logic [7:0]           spread_r;
  logic [7:0]           dr_r, dg_r, db_r;
  sector_t              sec_r;
  // stage 3 divider operands
  logic [DIV_NUM_W-1:0] l_num_r, s_num_r, r_num_r, g_num_r, b_num_r;
  logic [DIV_DEN_W-1:0] s_den_r, c_den_r;
  side_t                side3_r;
  side_t                side_r [DIV_STAGES];
  logic [7:0]           light_r [DIV_STAGES];
  // output
  hls_out_t             out_r;
  hls_out_t             out_nxt;

  logic [7:0]           hi, lo;
  logic [8:0]           sat_den;
  logic [LIGHT_PROD_W-1:0] light_prod;
  logic [DIV_QUO_W-1:0] l_q, s_q, r_q, g_q, b_q;
  logic signed [9:0]    hue_s;
  side_t                side_last;

  // global stall: advance when the output slot frees up
  assign en       = !vld_r[PIPE_DEPTH-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // max and min of the three channels
  always_comb begin
    hi = pix_r.red;
    if (pix_r.green > hi) hi = pix_r.green;
    if (pix_r.blue > hi) hi = pix_r.blue;
    lo = pix_r.red;
    if (pix_r.green < lo) lo = pix_r.green;
    if (pix_r.blue < lo) lo = pix_r.blue;
  end

  // saturation divisor depends on which half lightness lands in
  assign sat_den = (sum_r <= 9'(SAT_SPLIT)) ? sum_r : 9'(LIGHT_DEN) - sum_r;

  // lightness quotient by reciprocal multiply
  assign light_prod = LIGHT_PROD_W'(l_num_r) * LIGHT_PROD_W'(LIGHT_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r    <= in_data;
      sum_r    <= {1'b0, hi} + {1'b0, lo};
      spread_r <= hi - lo;
      dr_r     <= hi - pix_r.red;
      dg_r     <= hi - pix_r.green;
      db_r     <= hi - pix_r.blue;
      if (pix_r.red == hi) begin
        sec_r <= SEC_RED;
      end else if (pix_r.green == hi) begin
        sec_r <= SEC_GREEN;
      end else begin
        sec_r <= SEC_BLUE;
      end
      // rounded numerators
      l_num_r <= DIV_NUM_W'(sum_r) * DIV_NUM_W'(HLS_SCALE) + DIV_NUM_W'(RGB_FULL);
      s_num_r <= DIV_NUM_W'(spread_r) * DIV_NUM_W'(HLS_SCALE) + DIV_NUM_W'(sat_den >> 1);
      r_num_r <= DIV_NUM_W'(dr_r) * DIV_NUM_W'(HUE_SIXTH) + DIV_NUM_W'(spread_r >> 1);
      g_num_r <= DIV_NUM_W'(dg_r) * DIV_NUM_W'(HUE_SIXTH) + DIV_NUM_W'(spread_r >> 1);
      b_num_r <= DIV_NUM_W'(db_r) * DIV_NUM_W'(HUE_SIXTH) + DIV_NUM_W'(spread_r >> 1);
      s_den_r <= sat_den;
      c_den_r <= DIV_DEN_W'(spread_r);
      side3_r <= '{grey: (spread_r == '0), sector: sec_r};
      // side info and lightness travel with the divider stages
      side_r[0]  <= side3_r;
      light_r[0] <= light_prod[LIGHT_SHIFT +: 8];
      for (int i = 1; i < DIV_STAGES; i++) begin
        side_r[i]  <= side_r[i-1];
        light_r[i] <= light_r[i-1];
      end
      out_r <= out_nxt;
    end
  end

  // divider lanes
  hls_div u_div_s (.clk, .en, .num(s_num_r), .den(s_den_r), .quo(s_q));
  hls_div u_div_r (.clk, .en, .num(r_num_r), .den(c_den_r), .quo(r_q));
  hls_div u_div_g (.clk, .en, .num(g_num_r), .den(c_den_r), .quo(g_q));
  hls_div u_div_b (.clk, .en, .num(b_num_r), .den(c_den_r), .quo(b_q));

  assign l_q       = light_r[DIV_STAGES-1];
  assign side_last = side_r[DIV_STAGES-1];

  // hue by sector, wrapped into range
  always_comb begin
    case (side_last.sector)
      SEC_RED:   hue_s = 10'(signed'({2'b0, b_q})) - 10'(signed'({2'b0, g_q}));
      SEC_GREEN: hue_s = 10'(HUE_THIRD) + 10'(signed'({2'b0, r_q}))
                         - 10'(signed'({2'b0, b_q}));
      default:   hue_s = 10'(GREY_HUE) + 10'(signed'({2'b0, g_q}))
                         - 10'(signed'({2'b0, r_q}));
    endcase
    if (hue_s < 0) hue_s = hue_s + 10'(HLS_SCALE);
    if (hue_s > 10'(HLS_SCALE)) hue_s = hue_s - 10'(HLS_SCALE);
  end

  // final selection
  always_comb begin
    out_nxt.lightness  = (l_q > 8'(HLS_SCALE)) ? 8'(HLS_SCALE) : l_q;
    out_nxt.saturation = side_last.grey ? 8'd0 : s_q;
    out_nxt.hue        = side_last.grey ? 8'(GREY_HUE) : hue_s[7:0];
  end

  assign out_valid = vld_r[PIPE_DEPTH-1];
  assign out_data  = out_r;

  // checks
  `HLS_ASSERT_IMPL(a_ready_tracks_stall, 1'b1, in_ready == (!out_valid || out_ready))
  `HLS_ASSERT_NEXT(a_stall_freezes, !in_ready, $stable(vld_r))
  `HLS_ASSERT_IMPL(a_out_range, out_valid, (out_data.hue <= 8'(HLS_SCALE)) && (out_data.lightness <= 8'(HLS_SCALE)) && (out_data.saturation <= 8'(HLS_SCALE)))

endmodule

FILE: sim/tb_rgb_to_hls_converter.sv
// self-checking testbench for the rgb to hls converter
// depends on hls_pkg and rgb_to_hls_converter from rtl
module tb_rgb_to_hls_converter;
  import hls_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  pix_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  hls_out_t out_data;

  hls_out_t pending_hls[$];
  int       mismatch_count;
  int       cycle_count;
  bit       hold_off_req;
  int       hold_off_len;
  bit       stall_enable;

  rgb_to_hls_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // rounded channel delta scaled to one sixth of the hue circle
  function automatic int hue_delta(int hi, int ch, int spread);
    return ((hi - ch) * HUE_SIXTH + spread / 2) / spread;
  endfunction

  // predicted hue, lightness and saturation of one pixel
  function automatic hls_out_t convert_pixel(pix_in_t px);
    int r, g, b, hi, lo, sum, light, sat, hue, spread, rest, dr, dg, db;
    hls_out_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    sum = hi + lo;
    light = (sum * HLS_SCALE + RGB_FULL) / LIGHT_DEN;
    if (light > HLS_SCALE) light = HLS_SCALE;
    if (hi == lo) begin
      sat = 0;
      hue = GREY_HUE;
    end else begin
      spread = hi - lo;
      if (light <= HLS_SCALE / 2) begin
        sat = (spread * HLS_SCALE + sum / 2) / sum;
      end else begin
        rest = LIGHT_DEN - sum;
        sat = (spread * HLS_SCALE + rest / 2) / rest;
      end
      dr = hue_delta(hi, r, spread);
      dg = hue_delta(hi, g, spread);
      db = hue_delta(hi, b, spread);
      if (r == hi) hue = db - dg;
      else if (g == hi) hue = HUE_THIRD + dr - db;
      else hue = GREY_HUE + dg - dr;
      if (hue < 0) hue += HLS_SCALE;
      if (hue > HLS_SCALE) hue -= HLS_SCALE;
    end
    res.hue = hue[7:0];
    res.lightness = light[7:0];
    res.saturation = sat[7:0];
    return res;
  endfunction

  // send one pixel, predict at accept; valid stays high for the next beat
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pix_in_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    in_data <= px;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_hls.push_back(convert_pixel(px));
    @(negedge clk);
  endtask

  // drop valid and wait for the falling clock edge
  task automatic idle_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // burst sender: keeps valid high inside a burst
  task automatic send_burst(int n);
    pix_in_t px;
    for (int i = 0; i < n; i++) begin
      px = pix_in_t'($urandom);
      // bias toward near-grey and tied channels now and then
      case ($urandom_range(0, 7))
        0: px.green = px.red;
        1: px.blue = px.red ^ 8'($urandom_range(0, 3));
        2: begin px.green = px.red; px.blue = px.red; end
        default: ;
      endcase
      send_pixel(px.red, px.green, px.blue);
    end
  endtask

  task automatic wait_drained();
    while (pending_hls.size() != 0) @(negedge clk);
  endtask

  // receiver stall pattern and long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_len > 0) begin
      out_ready <= 1'b0;
      hold_off_len <= hold_off_len - 1;
    end else if (hold_off_req) begin
      out_ready <= 1'b0;
      hold_off_len <= 60;
      hold_off_req <= 1'b0;
    end else if (stall_enable) begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    hls_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_hls.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected beat %p", out_data);
      end else begin
        want = pending_hls.pop_front();
        if (out_data.hue !== want.hue || out_data.lightness !== want.lightness ||
            out_data.saturation !== want.saturation) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  // extremes, greys, each sector, ties, hue wrap
  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd127, 8'd128, 8'd128);
    send_pixel(8'd128, 8'd127, 8'd127);
    send_pixel(8'd200, 8'd10, 8'd180);
    send_pixel(8'd10, 8'd10, 8'd200);
    send_pixel(8'd170, 8'd85, 8'd85);
    send_pixel(8'd85, 8'd170, 8'd170);
    send_pixel(8'd255, 8'd255, 8'd254);
    idle_input();
    wait_drained();
  endtask

  // random bursts with gaps while the receiver stalls
  task automatic test_random_bursts(int n);
    int burst;
    int gap;
    stall_enable = 1'b1;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > n) burst = n;
      send_burst(burst);
      n -= burst;
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    idle_input();
  endtask

  // long receiver hold-off so the pipeline backs up into the input
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    send_burst(40);
    idle_input();
    wait_drained();
  endtask

  // full rate with no stalls
  task automatic test_full_rate();
    stall_enable = 1'b0;
    send_burst(200);
    idle_input();
    wait_drained();
    stall_enable = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    hold_off_req = 1'b0;
    hold_off_len = 0;
    stall_enable = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random_bursts(600);
    test_full_rate();
    test_random_bursts(540);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_hls.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
